/* hdl/int8_fir_filter_defines.svh */
// ----------------------------------------------------------------------------
// int8_fir_filter assertion macros
// Shared concurrent assertion helpers, clocked on clk; I8FIR_ASSERT is disabled in rst.
// ----------------------------------------------------------------------------
`ifndef INT8_FIR_FILTER_DEFINES_SVH
`define INT8_FIR_FILTER_DEFINES_SVH

`ifndef SYNTH
// Checked at every rising edge outside reset.
`define I8FIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define I8FIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I8FIR_ASSERT(lbl, prop, msg)
`define I8FIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/i8fir_pkg.sv */
// ----------------------------------------------------------------------------
// i8fir_pkg
// Widths, types and constants shared by the 8-bit FIR filter modules.
// ----------------------------------------------------------------------------
package i8fir_pkg;

  localparam int NUM_TAPS  = 8;
  localparam int HIST_LEN  = NUM_TAPS - 1;
  localparam int TAP_REGS  = 8;
  localparam int SAMPLE_W  = 8;
  localparam int TAP_W     = 8;
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int OUT_W     = 19;
  localparam int FILL_W    = $clog2(NUM_TAPS);
  localparam int CFG_IDX_W = 4;
  localparam int TAP_IDX_W = $clog2(TAP_REGS);
  localparam int HALF_TAPS = NUM_TAPS / 2;

  // Queue between the front end and the multiply-accumulate back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [OUT_W-1:0]    acc_t;

  // Element 0 is the oldest sample of the window.
  typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] window_t;

  typedef struct packed {
    logic    valid;
    window_t window;
  } win_push_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [TAP_W-1:0]     data;
  } cfg_wr_t;

endpackage

/* hdl/i8fir_queue.sv */
// ----------------------------------------------------------------------------
// i8fir_queue
// Short first-in first-out queue of complete sample windows.
// ----------------------------------------------------------------------------
`include "int8_fir_filter_defines.svh"

module i8fir_queue import i8fir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  win_push_t wr,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output window_t   rd_window
);

  window_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = wr.valid && !full;
  assign do_pop    = pop && !empty;
  assign rd_window = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr.window;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `I8FIR_ASSERT(a_q_not_full_and_empty, !(full && empty), "queue both full and empty")
  `I8FIR_ASSERT(a_q_count_bound, count <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")
  `I8FIR_ASSERT(a_q_count_up, (do_push && !do_pop) |=> (count == $past(count) + Q_CNT_W'(1)), "queue count did not rise on a lone push")

endmodule

/* hdl/i8fir_front.sv */
// ----------------------------------------------------------------------------
// i8fir_front
// Accepts samples, keeps the window history and fill count, and forwards a
// complete window for every sample that yields a result.
// ----------------------------------------------------------------------------
`include "int8_fir_filter_defines.svh"

module i8fir_front import i8fir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sample_t   sample,
  input  logic      block_start,
  input  logic      q_full,
  output win_push_t win_push
);

  sample_t             hist      [HIST_LEN];
  sample_t             hist_next [HIST_LEN];
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   fill_count_next;
  logic [FILL_W-1:0]   fill_eff;
  logic                accept;
  logic                produce;

  assign accept   = push && !q_full;
  // A block start empties the window before this sample is taken.
  assign fill_eff = block_start ? '0 : fill_count;
  assign produce  = (fill_eff == FILL_W'(HIST_LEN));

  always_comb begin
    win_push.valid = accept && produce;
    for (int j = 0; j < HIST_LEN; j++) begin
      win_push.window[j] = hist[j];
    end
    win_push.window[HIST_LEN] = sample;
  end

  always_comb begin
    fill_count_next = fill_count;
    for (int j = 0; j < HIST_LEN; j++) begin
      hist_next[j] = hist[j];
    end
    if (accept) begin
      if (!produce) begin
        for (int j = 0; j < HIST_LEN; j++) begin
          if (FILL_W'(j) == fill_eff) begin
            hist_next[j] = sample;
          end
        end
        fill_count_next = fill_eff + FILL_W'(1);
      end else begin
        for (int j = 0; j < HIST_LEN - 1; j++) begin
          hist_next[j] = hist[j + 1];
        end
        hist_next[HIST_LEN - 1] = sample;
        fill_count_next = fill_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HIST_LEN; j++) begin
      hist[j] <= hist_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  `I8FIR_ASSERT(a_fe_fill_bound, fill_count <= FILL_W'(HIST_LEN), "fill count beyond history length")
  `I8FIR_ASSERT(a_fe_start_refill, (accept && block_start) |=> (fill_count == FILL_W'(1)), "block start did not restart the window")
  `I8FIR_ASSERT(a_fe_full_window, win_push.valid |-> (fill_count == FILL_W'(HIST_LEN) && !block_start), "window forwarded before it was full")

endmodule

/* hdl/i8fir_mac.sv */
// ----------------------------------------------------------------------------
// i8fir_mac
// Back end: tap registers, parallel multipliers, a two-level adder tree and
// the result register seen on the output ports.
// ----------------------------------------------------------------------------
module i8fir_mac import i8fir_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    q_empty,
  input  window_t q_window,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output acc_t    filtered_value
);

  tap_t  taps [TAP_REGS];
  tap_t  coef [NUM_TAPS];
  prod_t prod [NUM_TAPS];
  acc_t  sum_lo;
  acc_t  sum_hi;
  acc_t  sum_lo_next;
  acc_t  sum_hi_next;
  logic  s1_valid;
  logic  s2_valid;
  logic  out_valid;
  acc_t  out_value;
  logic  out_ready;
  logic  s2_ready;
  logic  s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TAP_REGS; j++) begin
        taps[j] <= '0;
      end
    end else if (cfg.valid && (cfg.index < CFG_IDX_W'(TAP_REGS))) begin
      taps[cfg.index[TAP_IDX_W-1:0]] <= cfg.data;
    end
  end

  // Window positions without a register weigh with zero.
  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_coef
    if (g < TAP_REGS) begin : g_reg
      assign coef[g] = taps[g];
    end else begin : g_zero
      assign coef[g] = '0;
    end
  end

  // Each stage moves on when it is empty or its successor takes its content.
  assign out_ready = !out_valid || pop;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign q_pop     = s1_ready && !q_empty;
  assign empty     = !out_valid;
  assign filtered_value = out_value;

  always_comb begin
    sum_lo_next = '0;
    sum_hi_next = '0;
    for (int j = 0; j < HALF_TAPS; j++) begin
      sum_lo_next = sum_lo_next + OUT_W'(prod[j]);
    end
    for (int j = HALF_TAPS; j < NUM_TAPS; j++) begin
      sum_hi_next = sum_hi_next + OUT_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      for (int j = 0; j < NUM_TAPS; j++) begin
        prod[j] <= $signed(q_window[j]) * coef[j];
      end
    end
    if (s2_ready) begin
      sum_lo <= sum_lo_next;
      sum_hi <= sum_hi_next;
    end
    if (out_ready) begin
      out_value <= sum_lo + sum_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !q_empty;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

endmodule

/* hdl/int8_fir_filter.sv */
// A sample that completes a window passes through the queue, the product
// registers, the partial-sum registers and the result register to the outputs.
// Throughput: one sample per cycle, set by the eight parallel 8x8 multipliers
// and the registered two-level adder tree, unless a held output stalls it.
// Reset clears the tap registers, the window fill count and every valid flag;
// window history is not reset and is only read after it has been written.
// ----------------------------------------------------------------------------
// int8_fir_filter
// Streaming 8-tap FIR over signed 8-bit samples with a 19-bit signed result.
// ----------------------------------------------------------------------------
module int8_fir_filter import i8fir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  sample_t              sample,
  input  logic                 block_start,
  output logic                 empty,
  input  logic                 pop,
  output acc_t                 filtered_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TAP_W-1:0]     cfg_data
);

  win_push_t win_push;
  window_t   q_window;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  cfg_wr_t   cfg;

  // Every configuration transfer completes in the cycle it is offered.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign full      = q_full;

  i8fir_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .sample      (sample),
    .block_start (block_start),
    .q_full      (q_full),
    .win_push    (win_push)
  );

  i8fir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (win_push),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .rd_window (q_window)
  );

  i8fir_mac u_mac (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_window       (q_window),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .filtered_value (filtered_value)
  );

endmodule
